// ===== design/pmtud_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pmtud_pkg;

    localparam int TIMER_BITS     = 20;
    localparam int SIZE_BITS      = 14;
    localparam int ID_BITS        = 62;
    localparam int REQ_BITS       = 3;
    localparam int MODE_BITS      = 3;
    localparam int ATTEMPT_BITS   = 4;
    localparam int LOSS_BITS      = 8;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 20;

    localparam logic [SIZE_BITS-1:0]  BASE_MTU   = SIZE_BITS'(1200);
    localparam logic [SIZE_BITS-1:0]  ABS_MTU    = SIZE_BITS'(9000);
    localparam logic [SIZE_BITS-1:0]  RESET_MTU  = SIZE_BITS'(1500);
    localparam logic [SIZE_BITS-1:0]  SEARCH_GAP = SIZE_BITS'(20);
    localparam logic [TIMER_BITS-1:0] SEND_RETRY = TIMER_BITS'(1000);
    localparam logic [TIMER_BITS-1:0] TMAX       = '1;
    localparam logic [LOSS_BITS-1:0]  LOSS_MAX   = '1;

    // event codes
    localparam logic [REQ_BITS-1:0] REQ_TICK       = 3'd0;
    localparam logic [REQ_BITS-1:0] REQ_START      = 3'd1;
    localparam logic [REQ_BITS-1:0] REQ_SEND       = 3'd2;
    localparam logic [REQ_BITS-1:0] REQ_PROBE_ACK  = 3'd3;
    localparam logic [REQ_BITS-1:0] REQ_PROBE_LOST = 3'd4;
    localparam logic [REQ_BITS-1:0] REQ_PKT_LOST   = 3'd5;
    localparam logic [REQ_BITS-1:0] REQ_PKT_ACKED  = 3'd6;

    // discovery modes
    localparam logic [MODE_BITS-1:0] MODE_DISABLED = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_BASE     = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_SEARCH   = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_DONE     = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_ERROR    = 3'd4;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ENABLE       = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_MTU      = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PROBE_IVL    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RAISE_IVL    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BH_PERIOD    = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BH_THRESHOLD = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_PROBES   = 3'd6;

    typedef struct packed {
        logic [REQ_BITS-1:0]  req_type;
        logic [SIZE_BITS-1:0] pkt_len;
        logic [ID_BITS-1:0]   pkt_number;
        logic                 send_ok;
    } in_item_t;

    typedef struct packed {
        logic                  send_probe;
        logic [SIZE_BITS-1:0]  probe_bytes;
        logic [SIZE_BITS-1:0]  path_mtu;
        logic [MODE_BITS-1:0]  mode;
        logic                  black_hole;
    } out_item_t;

    typedef struct packed {
        logic                    enable;
        logic [SIZE_BITS-1:0]    max_mtu;
        logic [TIMER_BITS-1:0]   probe_interval_ms;
        logic [TIMER_BITS-1:0]   raise_interval_ms;
        logic [TIMER_BITS-1:0]   black_hole_period_ms;
        logic [LOSS_BITS-1:0]    black_hole_threshold;
        logic [ATTEMPT_BITS-1:0] max_probes;
    } cfg_t;

    typedef struct packed {
        logic [MODE_BITS-1:0]    disc_mode;
        logic [SIZE_BITS-1:0]    confirmed_mtu;
        logic [SIZE_BITS-1:0]    trial_size;
        logic [SIZE_BITS-1:0]    bound_low;
        logic [SIZE_BITS-1:0]    bound_high;
        logic [ATTEMPT_BITS-1:0] attempts;
        logic                    probe_outstanding;
        logic [ID_BITS-1:0]      probe_id;
        logic [TIMER_BITS-1:0]   probe_age;
        logic [TIMER_BITS-1:0]   countdown;
        logic                    countdown_armed;
        logic [LOSS_BITS-1:0]    loss_count;
        logic [TIMER_BITS-1:0]   loss_window_age;
    } state_t;

    // working copy of the state plus the probe request raised on this event
    typedef struct packed {
        state_t st;
        logic   req;
    } step_t;

    localparam cfg_t CFG_RESET = '{
        enable:               1'b1,
        max_mtu:              RESET_MTU,
        probe_interval_ms:    TIMER_BITS'(15000),
        raise_interval_ms:    TIMER_BITS'(600000),
        black_hole_period_ms: TIMER_BITS'(60000),
        black_hole_threshold: LOSS_BITS'(6),
        max_probes:           ATTEMPT_BITS'(3)
    };

    function automatic logic [SIZE_BITS-1:0] max_eff(input cfg_t c);
        logic [SIZE_BITS-1:0] m;
        begin
            m = c.max_mtu;
            if (m < BASE_MTU)
                m = BASE_MTU;
            else if (m > ABS_MTU)
                m = ABS_MTU;
            return m;
        end
    endfunction

    function automatic state_t init_state(input cfg_t c);
        state_t s;
        begin
            s = '0;
            s.disc_mode     = MODE_BASE;
            s.confirmed_mtu = BASE_MTU;
            s.bound_low     = BASE_MTU;
            s.bound_high    = max_eff(c);
            return s;
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/path_mtu_discovery_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Path MTU discovery controller. Takes one event per clock (tick, start, probe
// send result, probe ack/loss, large packet loss/ack) and returns exactly one
// result per event. The event is captured in an input register, one pass of
// compare-and-update logic computes the new state and the result, which lands
// in the result register. Throughput is one event per cycle; the input stalls
// only while the result register is full and the consumer stalls it. Config
// writes are always ready and take effect on the next event.
module path_mtu_discovery_controller (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire                                     in_valid,
    output logic                                    in_stall,
    input  wire pmtud_pkg::in_item_t                in_data,
    output logic                                    out_valid,
    input  wire                                     out_stall,
    output pmtud_pkg::out_item_t                    out_data,
    input  wire                                     cfg_valid,
    output logic                                    cfg_ready,
    input  wire [pmtud_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  wire [pmtud_pkg::CFG_DATA_BITS-1:0]      cfg_data
);

    logic                 in_valid_reg;
    pmtud_pkg::in_item_t  in_data_reg;
    logic                 out_valid_reg;
    pmtud_pkg::out_item_t out_data_reg;
    pmtud_pkg::state_t    state_reg;
    pmtud_pkg::state_t    state_next;
    pmtud_pkg::cfg_t      cfg_reg;
    pmtud_pkg::out_item_t result;
    logic                 consume;
    logic                 in_take;

    assign consume   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !consume;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    pmtud_step u_step (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .item       (in_data_reg),
        .state_next (state_next),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= pmtud_pkg::init_state(pmtud_pkg::CFG_RESET);
        end else begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (consume)
                in_valid_reg <= 1'b0;

            if (consume)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (consume)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg <= pmtud_pkg::CFG_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                pmtud_pkg::CFG_ENABLE:
                    cfg_reg.enable <= cfg_data[0];
                pmtud_pkg::CFG_MAX_MTU:
                    cfg_reg.max_mtu <= cfg_data[pmtud_pkg::SIZE_BITS-1:0];
                pmtud_pkg::CFG_PROBE_IVL:
                    cfg_reg.probe_interval_ms <= cfg_data[pmtud_pkg::TIMER_BITS-1:0];
                pmtud_pkg::CFG_RAISE_IVL:
                    cfg_reg.raise_interval_ms <= cfg_data[pmtud_pkg::TIMER_BITS-1:0];
                pmtud_pkg::CFG_BH_PERIOD:
                    cfg_reg.black_hole_period_ms <= cfg_data[pmtud_pkg::TIMER_BITS-1:0];
                pmtud_pkg::CFG_BH_THRESHOLD:
                    cfg_reg.black_hole_threshold <= cfg_data[pmtud_pkg::LOSS_BITS-1:0];
                pmtud_pkg::CFG_MAX_PROBES:
                    cfg_reg.max_probes <= cfg_data[pmtud_pkg::ATTEMPT_BITS-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_data_reg <= in_data;
        if (consume)
            out_data_reg <= result;
    end

    // a consumed event always shows up as a result transaction next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        consume |=> out_valid)
        else $error("consumed event produced no result");

    // no probe size without a probe request
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.send_probe |-> out_data.probe_bytes == '0)
        else $error("probe_bytes set without send_probe");

    // a black hole drops to error mode at the base MTU
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.black_hole |->
            out_data.mode == pmtud_pkg::MODE_ERROR && out_data.path_mtu == pmtud_pkg::BASE_MTU)
        else $error("black hole without fallback");

    // confirmed MTU stays within the absolute limits
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.path_mtu >= pmtud_pkg::BASE_MTU
                   && out_data.path_mtu <= pmtud_pkg::ABS_MTU)
        else $error("path MTU out of range");

endmodule

`default_nettype wire

// ===== design/pmtud_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Next-state and result logic for one event.
module pmtud_step (
    input  wire pmtud_pkg::state_t   state,
    input  wire pmtud_pkg::cfg_t     cfg,
    input  wire pmtud_pkg::in_item_t item,
    output pmtud_pkg::state_t        state_next,
    output pmtud_pkg::out_item_t     result
);

    // midpoint rounded up to 8, clamped to low+1..high
    function automatic logic [pmtud_pkg::SIZE_BITS-1:0] next_size(
        input logic [pmtud_pkg::SIZE_BITS-1:0] lo,
        input logic [pmtud_pkg::SIZE_BITS-1:0] hi
    );
        logic [pmtud_pkg::SIZE_BITS:0] sum;
        logic [pmtud_pkg::SIZE_BITS:0] mid;
        logic [pmtud_pkg::SIZE_BITS:0] lo1;
        logic [pmtud_pkg::SIZE_BITS:0] hi_x;
        begin
            sum  = {1'b0, lo} + {1'b0, hi};
            mid  = {1'b0, sum[pmtud_pkg::SIZE_BITS:1]} + (pmtud_pkg::SIZE_BITS+1)'(7);
            mid  = {mid[pmtud_pkg::SIZE_BITS:3], 3'b000};
            lo1  = {1'b0, lo} + (pmtud_pkg::SIZE_BITS+1)'(1);
            hi_x = {1'b0, hi};
            if (mid < lo1)
                mid = lo1;
            if (mid > hi_x)
                mid = hi_x;
            return mid[pmtud_pkg::SIZE_BITS-1:0];
        end
    endfunction

    function automatic pmtud_pkg::step_t request_probe(input pmtud_pkg::step_t w);
        pmtud_pkg::step_t r;
        begin
            r = w;
            r.st.countdown_armed = 1'b0;
            r.st.countdown       = '0;
            r.req                = 1'b1;
            return r;
        end
    endfunction

    function automatic pmtud_pkg::step_t enter_search(
        input pmtud_pkg::step_t w,
        input pmtud_pkg::cfg_t  c
    );
        pmtud_pkg::step_t r;
        begin
            r = w;
            r.st.disc_mode         = pmtud_pkg::MODE_SEARCH;
            r.st.bound_low         = r.st.confirmed_mtu;
            r.st.bound_high        = pmtud_pkg::max_eff(c);
            r.st.attempts          = '0;
            r.st.probe_outstanding = 1'b0;
            r.st.trial_size        = next_size(r.st.bound_low, r.st.bound_high);
            return request_probe(r);
        end
    endfunction

    function automatic pmtud_pkg::step_t continue_or_finish(
        input pmtud_pkg::step_t w,
        input pmtud_pkg::cfg_t  c
    );
        pmtud_pkg::step_t              r;
        logic [pmtud_pkg::SIZE_BITS:0] lim;
        begin
            r   = w;
            lim = {1'b0, r.st.bound_low} + {1'b0, pmtud_pkg::SEARCH_GAP};
            if ({1'b0, r.st.bound_high} < lim) begin
                r.st.disc_mode       = pmtud_pkg::MODE_DONE;
                r.st.countdown       = c.raise_interval_ms;
                r.st.countdown_armed = 1'b1;
            end else begin
                r.st.trial_size = next_size(r.st.bound_low, r.st.bound_high);
                r = request_probe(r);
            end
            return r;
        end
    endfunction

    function automatic pmtud_pkg::step_t probe_failed(
        input pmtud_pkg::step_t w,
        input pmtud_pkg::cfg_t  c
    );
        pmtud_pkg::step_t r;
        begin
            r = w;
            r.st.attempts          = r.st.attempts + pmtud_pkg::ATTEMPT_BITS'(1);
            r.st.probe_outstanding = 1'b0;
            if (r.st.attempts >= c.max_probes) begin
                r.st.bound_high = (r.st.trial_size != '0)
                                ? r.st.trial_size - pmtud_pkg::SIZE_BITS'(1) : '0;
                r.st.attempts   = '0;
                r = continue_or_finish(r, c);
            end else begin
                r.st.countdown       = c.probe_interval_ms;
                r.st.countdown_armed = 1'b1;
            end
            return r;
        end
    endfunction

    function automatic pmtud_pkg::step_t probe_success(
        input pmtud_pkg::step_t               w,
        input pmtud_pkg::cfg_t                c,
        input logic [pmtud_pkg::SIZE_BITS-1:0] size
    );
        pmtud_pkg::step_t               r;
        logic [pmtud_pkg::SIZE_BITS-1:0] sz;
        begin
            r  = w;
            sz = (size > r.st.bound_high) ? r.st.bound_high : size;
            r.st.probe_outstanding = 1'b0;
            r.st.attempts          = '0;
            if (sz > r.st.confirmed_mtu) begin
                r.st.confirmed_mtu = sz;
                r.st.bound_low     = sz;
            end
            return continue_or_finish(r, c);
        end
    endfunction

    function automatic pmtud_pkg::step_t timer_work(
        input pmtud_pkg::step_t w,
        input pmtud_pkg::cfg_t  c
    );
        pmtud_pkg::step_t              r;
        logic [pmtud_pkg::SIZE_BITS:0] lim;
        begin
            r = w;
            case (r.st.disc_mode)
                pmtud_pkg::MODE_BASE:
                begin
                    if (pmtud_pkg::max_eff(c) > pmtud_pkg::BASE_MTU + pmtud_pkg::SEARCH_GAP)
                        r = enter_search(r, c);
                end
                pmtud_pkg::MODE_SEARCH:
                begin
                    if (r.st.probe_outstanding) begin
                        if (r.st.probe_age >= c.probe_interval_ms) begin
                            r = probe_failed(r, c);
                        end else begin
                            // wait out the rest of the probe timeout
                            r.st.countdown       = c.probe_interval_ms - r.st.probe_age;
                            r.st.countdown_armed = 1'b1;
                        end
                    end else begin
                        r = request_probe(r);
                    end
                end
                pmtud_pkg::MODE_DONE:
                begin
                    lim = {1'b0, r.st.confirmed_mtu} + {1'b0, pmtud_pkg::SEARCH_GAP};
                    if ({1'b0, pmtud_pkg::max_eff(c)} > lim) begin
                        r = enter_search(r, c);
                    end else begin
                        r.st.countdown       = c.raise_interval_ms;
                        r.st.countdown_armed = 1'b1;
                    end
                end
                pmtud_pkg::MODE_ERROR:
                begin
                    r = enter_search(r, c);
                end
                pmtud_pkg::MODE_DISABLED:
                begin
                    r = w;
                end
                default:
                begin
                    r = w;
                end
            endcase
            return r;
        end
    endfunction

    pmtud_pkg::step_t               w;
    logic                           hole;
    logic [pmtud_pkg::LOSS_BITS-1:0] lc;
    logic                           probe_match;

    assign probe_match = (state.disc_mode == pmtud_pkg::MODE_SEARCH)
                       && state.probe_outstanding
                       && (state.probe_id == item.pkt_number);

    always_comb
    begin
        w     = '{st: state, req: 1'b0};
        hole  = 1'b0;
        lc    = state.loss_count;
        case (item.req_type)
            pmtud_pkg::REQ_TICK:
            begin
                if (w.st.probe_outstanding && (w.st.probe_age < pmtud_pkg::TMAX))
                    w.st.probe_age = w.st.probe_age + pmtud_pkg::TIMER_BITS'(1);
                if (w.st.loss_window_age < pmtud_pkg::TMAX)
                    w.st.loss_window_age = w.st.loss_window_age + pmtud_pkg::TIMER_BITS'(1);
                if (w.st.countdown_armed) begin
                    if (w.st.countdown <= pmtud_pkg::TIMER_BITS'(1)) begin
                        w.st.countdown       = '0;
                        w.st.countdown_armed = 1'b0;
                        w = timer_work(w, cfg);
                    end else begin
                        w.st.countdown = w.st.countdown - pmtud_pkg::TIMER_BITS'(1);
                    end
                end
            end
            pmtud_pkg::REQ_START:
            begin
                if (cfg.enable) begin
                    w.st = pmtud_pkg::init_state(cfg);
                    w = timer_work(w, cfg);
                end
            end
            pmtud_pkg::REQ_SEND:
            begin
                if (w.st.disc_mode == pmtud_pkg::MODE_SEARCH && !w.st.probe_outstanding
                    && !w.st.countdown_armed) begin
                    w.st.countdown_armed = 1'b1;
                    if (item.send_ok) begin
                        w.st.probe_outstanding = 1'b1;
                        w.st.probe_id          = item.pkt_number;
                        w.st.probe_age         = '0;
                        w.st.countdown         = cfg.probe_interval_ms;
                    end else begin
                        w.st.countdown = pmtud_pkg::SEND_RETRY;
                    end
                end
            end
            pmtud_pkg::REQ_PROBE_ACK:
            begin
                if (probe_match)
                    w = probe_success(w, cfg, item.pkt_len);
            end
            pmtud_pkg::REQ_PROBE_LOST:
            begin
                if (probe_match)
                    w = probe_failed(w, cfg);
            end
            pmtud_pkg::REQ_PKT_LOST:
            begin
                if (item.pkt_len > pmtud_pkg::BASE_MTU) begin
                    if (lc < pmtud_pkg::LOSS_MAX)
                        lc = lc + pmtud_pkg::LOSS_BITS'(1);
                    // first loss opens the observation window
                    if (lc == pmtud_pkg::LOSS_BITS'(1))
                        w.st.loss_window_age = '0;
                    if (lc >= cfg.black_hole_threshold) begin
                        if (w.st.loss_window_age < cfg.black_hole_period_ms) begin
                            hole                   = 1'b1;
                            w.st.disc_mode         = pmtud_pkg::MODE_ERROR;
                            w.st.confirmed_mtu     = pmtud_pkg::BASE_MTU;
                            w.st.bound_low         = pmtud_pkg::BASE_MTU;
                            w.st.bound_high        = pmtud_pkg::max_eff(cfg);
                            w.st.probe_outstanding = 1'b0;
                            w.st.attempts          = '0;
                            w.st.countdown         = cfg.black_hole_period_ms;
                            w.st.countdown_armed   = 1'b1;
                        end
                        lc = '0;
                    end
                    w.st.loss_count = lc;
                end
            end
            pmtud_pkg::REQ_PKT_ACKED:
            begin
                if (item.pkt_len > pmtud_pkg::BASE_MTU)
                    w.st.loss_count = '0;
            end
            default:
            begin
                w.req = 1'b0;
            end
        endcase
    end

    assign state_next         = w.st;
    assign result.send_probe  = w.req;
    assign result.probe_bytes = w.req ? w.st.trial_size : '0;
    assign result.path_mtu    = w.st.confirmed_mtu;
    assign result.mode        = w.st.disc_mode;
    assign result.black_hole  = hole;

endmodule

`default_nettype wire
